FILE: design/text_console_writer_assert.svh
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TCW_ASSERT_NOW(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("text console check failed");

// next-cycle implication, checked out of reset
`define TCW_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("text console check failed");

`endif

FILE: design/tcw_pkg.sv
package tcw_pkg;

	// screen geometry
	localparam int ROW_COUNT    = 25;
	localparam int COLUMN_COUNT = 80;
	localparam int CELL_COUNT   = ROW_COUNT * COLUMN_COUNT;
	localparam int COPY_COUNT   = CELL_COUNT - COLUMN_COUNT;

	// field widths
	localparam int CELL_W = 11;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int BYTE_W = 8;

	// character codes and reset values
	localparam logic [BYTE_W-1:0] BLANK_CHAR       = 8'h20;
	localparam logic [BYTE_W-1:0] NEWLINE_CHAR     = 8'h0A;
	localparam logic [BYTE_W-1:0] NULL_CHAR        = 8'h00;
	localparam logic [BYTE_W-1:0] TEXT_ATTR_RST    = 8'h07;
	localparam logic [BYTE_W-1:0] CURSOR_ATTR_RST  = 8'h70;

	// configuration register indexes
	localparam logic [1:0] CFG_TEXT_ATTR   = 2'd0;
	localparam logic [1:0] CFG_CURSOR_ATTR = 2'd1;
	localparam logic [1:0] CFG_CURSOR_EN   = 2'd2;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} tcw_cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_BLANK,
		ST_DONE
	} tcw_state_t;

	// one screen cell
	typedef struct packed {
		logic [BYTE_W-1:0] attr;
		logic [BYTE_W-1:0] chr;
	} tcw_cell_t;

	// screen memory write request, separate enables per byte
	typedef struct packed {
		logic              we_chr;
		logic              we_attr;
		logic [CELL_W-1:0] addr;
		tcw_cell_t         data;
	} tcw_wr_t;

	// screen memory read request
	typedef struct packed {
		logic              re;
		logic [CELL_W-1:0] addr;
	} tcw_rd_t;

endpackage

FILE: design/tcw_screen_ram.sv
module tcw_screen_ram import tcw_pkg::*; (
	input  logic      clk,
	input  tcw_wr_t   wr,
	input  tcw_rd_t   rd,
	output tcw_cell_t dout
);

	logic [BYTE_W-1:0] chr_mem  [CELL_COUNT];
	logic [BYTE_W-1:0] attr_mem [CELL_COUNT];
	tcw_cell_t         dout_q;

	// write port with byte enables
	always_ff @(posedge clk) begin
		if (wr.we_chr) begin
			chr_mem[wr.addr] <= wr.data.chr;
		end
		if (wr.we_attr) begin
			attr_mem[wr.addr] <= wr.data.attr;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd.re) begin
			dout_q.chr  <= chr_mem[rd.addr];
			dout_q.attr <= attr_mem[rd.addr];
		end
	end

	assign dout = dout_q;

endmodule

FILE: design/text_console_writer.sv
// Text console of 25 rows by 80 cells with a cursor. A command is taken when start is high
// and busy is low; each command gives exactly one result on done, one cycle wide, which the
// receiver must take then since it cannot stall. A put of a plain character, a put of byte
// zero and the unused command answer in the cycle after acceptance; a read answers through
// the ST_READ state, which holds the registered memory read, and then the done register; a
// newline that does not scroll answers in the cycle after acceptance. A scroll (newline on
// the last row, or a put into the last cell) walks the screen memory one cell per cycle: a
// copy phase, blanking of the last row and a result state. A clear command sweeps all 2000
// cells before its result. After reset the block clears the screen with busy high;
// configuration writes are taken only while the block is idle and start is low (cfg_ready).
module text_console_writer import tcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        command,
	input  logic [BYTE_W-1:0] character,
	input  logic [CELL_W-1:0] cell_index,
	output logic              done,
	output logic [BYTE_W-1:0] cell_character,
	output logic [BYTE_W-1:0] cell_attribute,
	output logic [ROW_W-1:0]  cursor_row,
	output logic [COL_W-1:0]  cursor_column,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [BYTE_W-1:0] cfg_data
);

	tcw_state_t        state_q, state_d;
	logic [CELL_W-1:0] idx_q;
	logic              report_q;
	logic [CELL_W-1:0] cursor_cell_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [BYTE_W-1:0] text_attr_q, cursor_attr_q;
	logic              cursor_en_q;
	logic [BYTE_W-1:0] rd_chr_q, rd_attr_q;
	logic              done_q, done_d;
	logic              rd_hit_s1, rd_cursor_s1;
	logic              copy_v_s1;
	logic [CELL_W-1:0] copy_addr_s1;

	tcw_wr_t   wr;
	tcw_rd_t   rd;
	tcw_cell_t dout;

	logic accept, is_put, put_nl, put_zero, last_row, last_cell, need_scroll, copy_end;

	// input decode
	assign accept      = start && !busy;
	assign is_put      = command == CMD_PUT;
	assign put_nl      = character == NEWLINE_CHAR;
	assign put_zero    = character == NULL_CHAR;
	assign last_row    = row_q == ROW_W'(ROW_COUNT - 1);
	assign last_cell   = cursor_cell_q == CELL_W'(CELL_COUNT - 1);
	assign need_scroll = accept && is_put && !put_zero && (put_nl ? last_row : last_cell);
	assign copy_end    = idx_q == CELL_W'(COPY_COUNT);

	tcw_screen_ram u_ram (
		.clk  (clk),
		.wr   (wr),
		.rd   (rd),
		.dout (dout)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (idx_q == CELL_W'(CELL_COUNT - 1)) begin
					state_d = report_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (command)
						CMD_PUT:   state_d = need_scroll ? ST_SCROLL : ST_IDLE;
						CMD_READ:  state_d = ST_READ;
						CMD_CLEAR: state_d = ST_CLEAR;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ:   state_d = ST_IDLE;
			ST_SCROLL: begin
				if (copy_end) begin
					state_d = ST_BLANK;
				end
			end
			ST_BLANK: begin
				if (idx_q == CELL_W'(CELL_COUNT - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory control and result strobe
	always_comb begin
		wr     = '0;
		rd     = '0;
		done_d = 1'b0;
		busy   = 1'b1;
		case (state_q)
			ST_CLEAR, ST_BLANK: begin
				wr.we_chr    = 1'b1;
				wr.we_attr   = 1'b1;
				wr.addr      = idx_q;
				wr.data.chr  = BLANK_CHAR;
				wr.data.attr = text_attr_q;
			end
			ST_IDLE: begin
				busy         = 1'b0;
				// put writes the cursor cell, newline only restores its attribute
				wr.we_attr   = accept && is_put && !put_zero;
				wr.we_chr    = accept && is_put && !put_zero && !put_nl;
				wr.addr      = cursor_cell_q;
				wr.data.chr  = character;
				wr.data.attr = text_attr_q;
				rd.re        = accept && (command == CMD_READ)
					&& (cell_index < CELL_W'(CELL_COUNT));
				rd.addr      = cell_index;
				done_d       = accept && (is_put ? !need_scroll
					: (command != CMD_READ && command != CMD_CLEAR));
			end
			ST_READ:   done_d = 1'b1;
			ST_SCROLL: begin
				// read one row ahead, write the previous read back one row up
				rd.re      = !copy_end;
				rd.addr    = idx_q + CELL_W'(COLUMN_COUNT);
				wr.we_chr  = copy_v_s1;
				wr.we_attr = copy_v_s1;
				wr.addr    = copy_addr_s1;
				wr.data    = dout;
			end
			ST_DONE:   done_d = 1'b1;
			default:   busy = 1'b1;
		endcase
	end

	// sequencer state and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			idx_q    <= '0;
			report_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			case (state_q)
				ST_CLEAR, ST_BLANK: idx_q <= idx_q + CELL_W'(1);
				ST_SCROLL: begin
					if (!copy_end) begin
						idx_q <= idx_q + CELL_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept && (command == CMD_CLEAR || need_scroll)) begin
						idx_q <= '0;
					end
					if (accept && command == CMD_CLEAR) begin
						report_q <= 1'b1;
					end
				end
				default: idx_q <= idx_q;
			endcase
		end
	end

	// copy pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_v_s1 <= 1'b0;
		end else begin
			copy_v_s1 <= (state_q == ST_SCROLL) && rd.re;
		end
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= idx_q;
	end

	// cursor position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_cell_q <= '0;
			row_q         <= '0;
			col_q         <= '0;
		end else if (accept && command == CMD_CLEAR) begin
			cursor_cell_q <= '0;
			row_q         <= '0;
			col_q         <= '0;
		end else if (accept && is_put && !put_zero) begin
			if (need_scroll) begin
				cursor_cell_q <= CELL_W'(COPY_COUNT);
				row_q         <= ROW_W'(ROW_COUNT - 1);
				col_q         <= '0;
			end else if (put_nl) begin
				cursor_cell_q <= cursor_cell_q + CELL_W'(COLUMN_COUNT) - CELL_W'(col_q);
				row_q         <= row_q + ROW_W'(1);
				col_q         <= '0;
			end else begin
				cursor_cell_q <= cursor_cell_q + CELL_W'(1);
				if (col_q == COL_W'(COLUMN_COUNT - 1)) begin
					row_q <= row_q + ROW_W'(1);
					col_q <= '0;
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// read result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_chr_q  <= '0;
			rd_attr_q <= '0;
		end else if (accept) begin
			rd_chr_q  <= '0;
			rd_attr_q <= '0;
		end else if (state_q == ST_READ && rd_hit_s1) begin
			rd_chr_q  <= dout.chr;
			rd_attr_q <= rd_cursor_s1 ? cursor_attr_q : dout.attr;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_hit_s1    <= cell_index < CELL_W'(CELL_COUNT);
			rd_cursor_s1 <= (cell_index == cursor_cell_q) && cursor_en_q;
		end
	end

	// configuration registers, written only with no transaction in flight
	assign cfg_ready = !busy && !start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q   <= TEXT_ATTR_RST;
			cursor_attr_q <= CURSOR_ATTR_RST;
			cursor_en_q   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TEXT_ATTR:   text_attr_q   <= cfg_data;
				CFG_CURSOR_ATTR: cursor_attr_q <= cfg_data;
				CFG_CURSOR_EN:   cursor_en_q   <= cfg_data[0];
				default:         cursor_en_q   <= cursor_en_q;
			endcase
		end
	end

	// result ports
	assign done           = done_q;
	assign cell_character = rd_chr_q;
	assign cell_attribute = rd_attr_q;
	assign cursor_row     = row_q;
	assign cursor_column  = col_q;

	`include "text_console_writer_assert.svh"

	// cursor cell number always matches row and column
	`TCW_ASSERT_NOW(a_cursor_cell, clk, arst_n, 1'b1, int'(cursor_cell_q) == int'(row_q) * COLUMN_COUNT + int'(col_q))

	// cursor never leaves the screen
	`TCW_ASSERT_NOW(a_cursor_range, clk, arst_n, 1'b1, row_q < ROW_W'(ROW_COUNT) && col_q < COL_W'(COLUMN_COUNT))

	// a plain put that does not scroll answers in the next cycle
	`TCW_ASSERT_NEXT(a_put_fast, clk, arst_n, accept && is_put && !put_nl && !put_zero && !last_cell, done)

	// copy writes happen only while scrolling
	`TCW_ASSERT_NOW(a_copy_scope, clk, arst_n, copy_v_s1, state_q == ST_SCROLL)

endmodule
